// File: hdl/mcfe_pkg.sv
// ----------------------------------------------------------------------------
// Modbus client frame engine package
// Shared types, codes and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mcfe_pkg;

  localparam int FrameBytes = 260;
  localparam int MaxReqLen  = FrameBytes - 9;
  localparam logic [8:0] CountMax = 9'd511;

  // Input operation codes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_REQ   = 2'd1;
  localparam logic [1:0] OP_RESP  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_REQ_BYTE  = 2'd0;
  localparam logic [1:0] KIND_RESP_BYTE = 2'd1;
  localparam logic [1:0] KIND_REQ_VERD  = 2'd2;
  localparam logic [1:0] KIND_RESP_VERD = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_FRAME = 2'd2;
  localparam logic [1:0] ST_EXC   = 2'd3;

  // Register indexes.
  localparam logic [0:0] REG_LINK_MODE = 1'd0;
  localparam logic [0:0] REG_UNIT      = 1'd1;

  // One result item as it travels through the queue.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic [1:0] status;
    logic [7:0] resp_unit;
    logic [7:0] resp_function;
    logic [8:0] resp_payload_len;
    logic       end_of_run;
  } result_t;

  localparam int ResultW = $bits(result_t);

  // Reflected CRC-16 update over one byte.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/mcfe_front.sv
// ----------------------------------------------------------------------------
// Modbus client frame engine front
// Accepts items, keeps request and response state, and produces up to eight
// results per item into a queue word.
// ----------------------------------------------------------------------------
module mcfe_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         link_mode,
  input  logic [7:0]                   unit_address,
  input  logic                         take,
  input  logic [1:0]                   op,
  input  logic [7:0]                   data,
  input  logic [7:0]                   length,
  input  logic                         last,
  output mcfe_pkg::result_t [7:0]      res,
  output logic [3:0]                   res_count
);
  import mcfe_pkg::*;

  logic [15:0] transaction_counter;
  logic [15:0] request_crc;
  logic [7:0]  request_bytes_left;
  logic        request_open;
  logic [15:0] response_crc;
  logic [8:0]  response_count;
  logic [7:0]  holdback [2];
  logic [7:0]  header [8];
  logic        response_bad;

  logic [15:0] tc_next, rcrc_next, pcrc_next;
  logic [7:0]  left_next;
  logic        open_next, bad_next, clear_resp;
  logic [15:0] crc_a;
  logic [8:0]  len9, pdu;
  logic [1:0]  st;
  logic [7:0]  fn, h_unit, h_fn, h_b2, h_b3, h_b4, h_b5, hb0, hb1;
  logic [8:0]  plen;
  logic [8:0]  mlen;
  logic        ok_rtu, ok_tcp;

  function automatic result_t mk(input logic [1:0] k, input logic [7:0] b,
                                 input logic [1:0] s);
    result_t r;
    r = '0;
    r.kind = k;
    r.byte_out = b;
    r.status = s;
    return r;
  endfunction

  // Item decode and result generation.
  always_comb begin
    res = '0;
    res_count = 4'd0;
    tc_next = transaction_counter;
    pcrc_next = request_crc;
    left_next = request_bytes_left;
    open_next = request_open;
    rcrc_next = response_crc;
    bad_next = response_bad;
    clear_resp = 1'b0;
    crc_a = '0;
    len9 = '0; pdu = '0; st = ST_OK; fn = '0; plen = '0;
    hb0 = holdback[0]; hb1 = holdback[1];
    h_unit = header[0]; h_fn = header[1]; h_b2 = header[2]; h_b3 = header[3];
    h_b4 = header[4]; h_b5 = header[5];
    mlen = length + 9'd2;
    ok_rtu = 1'b0; ok_tcp = 1'b0;
    unique case (op)
      OP_START: begin
        if (data == 8'd0 || {1'b0, length} > 9'(MaxReqLen)) begin
          res[0] = mk(KIND_REQ_VERD, 8'd0, ST_INVAL);
          res_count = 4'd1;
        end else if (!link_mode) begin
          crc_a = crc_step(crc_step(16'hFFFF, unit_address), data);
          pcrc_next = crc_a;
          res[0] = mk(KIND_REQ_BYTE, unit_address, ST_OK);
          res[1] = mk(KIND_REQ_BYTE, data, ST_OK);
          left_next = length;
          open_next = 1'b1;
          res_count = 4'd2;
          if (length == 8'd0) begin
            res[2] = mk(KIND_REQ_BYTE, crc_a[7:0], ST_OK);
            res[3] = mk(KIND_REQ_BYTE, crc_a[15:8], ST_OK);
            open_next = 1'b0;
            res_count = 4'd4;
          end
        end else begin
          tc_next = transaction_counter + 16'd1;
          res[0] = mk(KIND_REQ_BYTE, tc_next[15:8], ST_OK);
          res[1] = mk(KIND_REQ_BYTE, tc_next[7:0], ST_OK);
          res[2] = mk(KIND_REQ_BYTE, 8'd0, ST_OK);
          res[3] = mk(KIND_REQ_BYTE, 8'd0, ST_OK);
          res[4] = mk(KIND_REQ_BYTE, {7'd0, mlen[8]}, ST_OK);
          res[5] = mk(KIND_REQ_BYTE, mlen[7:0], ST_OK);
          res[6] = mk(KIND_REQ_BYTE, unit_address, ST_OK);
          res[7] = mk(KIND_REQ_BYTE, data, ST_OK);
          res_count = 4'd8;
          left_next = length;
          open_next = length != 8'd0;
        end
      end
      OP_REQ: begin
        if (!request_open || request_bytes_left == 8'd0) begin
          open_next = 1'b0;
          res[0] = mk(KIND_REQ_VERD, 8'd0, ST_INVAL);
          res_count = 4'd1;
        end else begin
          res[0] = mk(KIND_REQ_BYTE, data, ST_OK);
          res_count = 4'd1;
          left_next = request_bytes_left - 8'd1;
          if (!link_mode) begin
            crc_a = crc_step(request_crc, data);
            pcrc_next = crc_a;
            if (left_next == 8'd0) begin
              res[1] = mk(KIND_REQ_BYTE, crc_a[7:0], ST_OK);
              res[2] = mk(KIND_REQ_BYTE, crc_a[15:8], ST_OK);
              res_count = 4'd3;
              open_next = 1'b0;
            end
          end else if (left_next == 8'd0) begin
            open_next = 1'b0;
          end
        end
      end
      OP_RESP: begin
        if (response_count >= 9'(FrameBytes) || response_count >= CountMax)
          bad_next = 1'b1;
        case (response_count)
          9'd0: h_unit = data;
          9'd1: h_fn = data;
          9'd2: h_b2 = data;
          9'd3: h_b3 = data;
          9'd4: h_b4 = data;
          9'd5: h_b5 = data;
          default: ;
        endcase
        if (!link_mode) begin
          if (response_count < 9'd2) begin
            rcrc_next = crc_step(response_crc, data);
          end else begin
            if (response_count >= 9'd4) begin
              rcrc_next = crc_step(response_crc, holdback[0]);
              res[0] = mk(KIND_RESP_BYTE, holdback[0], ST_OK);
              res_count = 4'd1;
            end
            hb0 = holdback[1];
            hb1 = data;
          end
        end else if (response_count >= 9'd8) begin
          res[0] = mk(KIND_RESP_BYTE, data, ST_OK);
          res_count = 4'd1;
        end
        if (last) begin
          len9 = response_count + 9'd1;
          pdu = {h_b4[0], h_b5};
          ok_rtu = !bad_next && len9 >= 9'd5 && {hb1, hb0} == rcrc_next &&
                   h_unit == unit_address && h_b4[7:1] == 7'd0;
          // Header bytes 6 and 7 come from the stored copy only.
          if (!link_mode) begin
            ok_rtu = !bad_next && len9 >= 9'd5 && {hb1, hb0} == rcrc_next &&
                     h_unit == unit_address;
            fn = h_fn;
            plen = len9 - 9'd4;
            st = !ok_rtu ? ST_FRAME : (fn[7] ? ST_EXC : ST_OK);
          end else begin
            ok_tcp = !bad_next && len9 >= 9'd9 && h_b2 == 8'd0 && h_b3 == 8'd0 &&
                     header[6] == unit_address && h_b4[7:1] == 7'd0 &&
                     pdu >= 9'd2 && (pdu + 9'd6) == len9;
            fn = header[7];
            plen = len9 - 9'd8;
            st = !ok_tcp ? ST_FRAME : (fn[7] ? ST_EXC : ST_OK);
          end
          res[res_count[2:0]] = mk(KIND_RESP_VERD, 8'd0, st);
          if (st == ST_OK) begin
            res[res_count[2:0]].resp_unit = unit_address;
            res[res_count[2:0]].resp_function = fn;
            res[res_count[2:0]].resp_payload_len = plen;
          end
          res_count = res_count + 4'd1;
          clear_resp = 1'b1;
        end
      end
      default: ;
    endcase
    if (res_count != 4'd0) res[res_count[2:0] - 3'd1].end_of_run = 1'b1;
  end

  // State update on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      transaction_counter <= '0;
      request_crc <= 16'hFFFF;
      request_bytes_left <= '0;
      request_open <= 1'b0;
      response_crc <= 16'hFFFF;
      response_count <= '0;
      holdback[0] <= '0;
      holdback[1] <= '0;
      for (int i = 0; i < 8; i++) header[i] <= '0;
      response_bad <= 1'b0;
    end else if (take) begin
      transaction_counter <= tc_next;
      request_crc <= pcrc_next;
      request_bytes_left <= left_next;
      request_open <= open_next;
      if (op == OP_RESP) begin
        if (clear_resp) begin
          response_crc <= 16'hFFFF;
          response_count <= '0;
          holdback[0] <= '0;
          holdback[1] <= '0;
          for (int i = 0; i < 8; i++) header[i] <= '0;
          response_bad <= 1'b0;
        end else begin
          response_crc <= rcrc_next;
          if (response_count < CountMax) response_count <= response_count + 9'd1;
          holdback[0] <= hb0;
          holdback[1] <= hb1;
          if (response_count < 9'd8) header[response_count[2:0]] <= data;
          response_bad <= bad_next;
        end
      end
    end
  end

endmodule

// File: hdl/mcfe_queue.sv
// ----------------------------------------------------------------------------
// Modbus client frame engine queue
// Holds result groups of one item each, two deep, between front and back.
// ----------------------------------------------------------------------------
module mcfe_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mcfe_pkg::result_t [7:0] push_res,
  input  logic [3:0]              push_count,
  output logic                    full,
  output logic                    empty,
  output mcfe_pkg::result_t [7:0] head_res,
  output logic [3:0]              head_count,
  input  logic                    pop
);
  import mcfe_pkg::*;

  result_t [7:0] slot_res [2];
  logic [3:0]    slot_count [2];
  logic [0:0]    rd_ptr, wr_ptr;
  logic [1:0]    fill;

  assign full = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign head_res = slot_res[rd_ptr];
  assign head_count = slot_count[rd_ptr];

  // Slot writes.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_res[wr_ptr] <= push_res;
      slot_count[wr_ptr] <= push_count;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hdl/mcfe_back.sv
// ----------------------------------------------------------------------------
// Modbus client frame engine back
// Walks the head group of the queue and presents one result per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module mcfe_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    empty,
  input  mcfe_pkg::result_t [7:0] head_res,
  input  logic [3:0]              head_count,
  output logic                    pop,
  output logic                    out_valid,
  output mcfe_pkg::result_t       out_res,
  input  logic                    out_stall
);
  import mcfe_pkg::*;

  logic [2:0] idx;
  logic       send;

  assign out_valid = !empty;
  assign out_res = head_res[idx];
  assign send = out_valid && !out_stall;
  assign pop = send && ({1'b0, idx} + 4'd1 == head_count);

  // Position within the current group.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (send) begin
      idx <= pop ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

// File: hdl/modbus_client_frame_engine.sv
// ----------------------------------------------------------------------------
// Modbus client frame engine
// RTU/TCP request framer and response deframer with CRC-16.
// ----------------------------------------------------------------------------
// Input items (op, data, length, last) are taken with in_valid/in_stall and
// results (kind, byte_out, status, resp_*, end_of_run) leave on
// out_valid/out_stall. Each item is decoded in the cycle it is accepted and
// its zero to eight results go into a two-group queue; an item's results are
// registered in a queue slot and the back end then sends them one result per
// cycle while out_stall is low. Items that cause no result are not queued. Input
// is taken whenever the queue has room, so one item a cycle is sustained while
// each makes at most one result and the receiver does not stall.
// When the receiver stalls, the queue fills and in_stall rises.
// Reset clears the request and response state, the transaction counter and
// the queue; link_mode resets to RTU and unit_address to 1. The registers are
// written over the APB port at addresses 0 and 4 and read back there.
// ----------------------------------------------------------------------------
module modbus_client_frame_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  data,
  input  logic [7:0]  length,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  byte_out,
  output logic [1:0]  status,
  output logic [7:0]  resp_unit,
  output logic [7:0]  resp_function,
  output logic [8:0]  resp_payload_len,
  output logic        end_of_run
);
  import mcfe_pkg::*;

  logic          link_mode;
  logic [7:0]    unit_address;
  logic          take, full, empty, pop, push;
  result_t [7:0] f_res, h_res;
  logic [3:0]    f_count, h_count;
  result_t       o;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode <= 1'b0;
      unit_address <= 8'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_LINK_MODE) link_mode <= pwdata[0];
      else unit_address <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_UNIT) prdata[7:0] = unit_address;
    else prdata[0] = link_mode;
  end

  assign in_stall = full;
  assign take = in_valid && !full;
  assign push = take && f_count != 4'd0;

  mcfe_front u_front (
    .clk, .rst, .link_mode, .unit_address, .take, .op, .data, .length, .last,
    .res(f_res), .res_count(f_count)
  );

  mcfe_queue u_queue (
    .clk, .rst, .push, .push_res(f_res), .push_count(f_count), .full, .empty,
    .head_res(h_res), .head_count(h_count), .pop
  );

  mcfe_back u_back (
    .clk, .rst, .empty, .head_res(h_res), .head_count(h_count), .pop,
    .out_valid, .out_res(o), .out_stall
  );

  assign kind = o.kind;
  assign byte_out = o.byte_out;
  assign status = o.status;
  assign resp_unit = o.resp_unit;
  assign resp_function = o.resp_function;
  assign resp_payload_len = o.resp_payload_len;
  assign end_of_run = o.end_of_run;

endmodule

// File: hdl/mcfe_checker.sv
// ----------------------------------------------------------------------------
// Modbus client frame engine checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mcfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] byte_out,
  input logic [1:0] status,
  input logic       end_of_run
);
  import mcfe_pkg::*;

  // A stalled result stays valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");

  // Verdicts always end a run.
  a_verd_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REQ_VERD || kind == KIND_RESP_VERD) |-> end_of_run)
    else $error("verdict not last");

  // Verdicts carry no byte.
  a_verd_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REQ_VERD || kind == KIND_RESP_VERD) |-> byte_out == 8'd0)
    else $error("verdict with byte");

  // Byte results carry no status.
  a_byte_st: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REQ_BYTE || kind == KIND_RESP_BYTE) |-> status == ST_OK)
    else $error("byte with status");

endmodule

bind modbus_client_frame_engine mcfe_checker u_checker (
  .clk, .rst, .out_valid, .out_stall, .kind, .byte_out, .status, .end_of_run
);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Modbus client frame engine testbench
// Drives request and response items with random gaps on both channels, writes
// the mode and unit registers between phases, and checks every result against
// a behavioral model of the framer and deframer kept in this file.
// ----------------------------------------------------------------------------
import mcfe_pkg::*;

// Holds the results that the modeled engine has produced but the block has
// not yet sent, and checks each result that comes out.
class frame_scoreboard;
  result_t pending[$];
  int errors;

  // Note the results caused by one accepted input item.
  function void note_item(result_t res[$]);
    foreach (res[i]) pending.push_back(res[i]);
  endfunction

  // Compare one result from the block with the oldest pending one.
  function void check_result(result_t got);
    result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result kind %0d byte %0h", $time, got.kind, got.byte_out);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.kind != want.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
      errors++;
    end
    if (got.byte_out != want.byte_out) begin
      $display("%0t: byte_out expected %0h actual %0h", $time, want.byte_out, got.byte_out);
      errors++;
    end
    if (got.status != want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.resp_unit != want.resp_unit) begin
      $display("%0t: resp_unit expected %0h actual %0h", $time, want.resp_unit,
               got.resp_unit);
      errors++;
    end
    if (got.resp_function != want.resp_function) begin
      $display("%0t: resp_function expected %0h actual %0h", $time,
               want.resp_function, got.resp_function);
      errors++;
    end
    if (got.resp_payload_len != want.resp_payload_len) begin
      $display("%0t: resp_payload_len expected %0d actual %0d", $time,
               want.resp_payload_len, got.resp_payload_len);
      errors++;
    end
    if (got.end_of_run != want.end_of_run) begin
      $display("%0t: end_of_run expected %0d actual %0d", $time, want.end_of_run,
               got.end_of_run);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int WatchdogLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = '0;
  logic [7:0]  data = '0;
  logic [7:0]  length = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  byte_out;
  logic [1:0]  status;
  logic [7:0]  resp_unit;
  logic [7:0]  resp_function;
  logic [8:0]  resp_payload_len;
  logic        end_of_run;

  modbus_client_frame_engine uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  frame_scoreboard board = new();

  // Model state.
  logic        mdl_tcp;
  logic [7:0]  mdl_unit;
  logic [15:0] mdl_tid;
  logic [15:0] mdl_req_crc;
  logic [7:0]  mdl_req_left;
  logic        mdl_req_open;
  logic [15:0] mdl_rsp_crc;
  logic [8:0]  mdl_rsp_count;
  logic [7:0]  mdl_hold [2];
  logic [7:0]  mdl_hdr [8];
  logic        mdl_rsp_bad;
  int          quiet_cycles;
  logic        receiver_busy;

  // Reflected CRC-16 over one byte, polynomial 0xA001.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic result_t mk(logic [1:0] k, logic [7:0] b, logic [1:0] st);
    result_t r;
    r = '0;
    r.kind = k;
    r.byte_out = b;
    r.status = st;
    return r;
  endfunction

  function automatic void clear_response();
    mdl_rsp_crc = 16'hFFFF;
    mdl_rsp_count = '0;
    mdl_hold[0] = '0;
    mdl_hold[1] = '0;
    foreach (mdl_hdr[i]) mdl_hdr[i] = '0;
    mdl_rsp_bad = 1'b0;
  endfunction

  // Verdict for a finished response frame of len bytes.
  function automatic result_t response_verdict(int unsigned len);
    result_t r;
    logic [1:0] st;
    logic [7:0] fn;
    int unsigned plen, pdu;
    st = ST_OK;
    if (!mdl_tcp) begin
      if (mdl_rsp_bad || len < 5 || {mdl_hold[1], mdl_hold[0]} != mdl_rsp_crc ||
          mdl_hdr[0] != mdl_unit) st = ST_FRAME;
      else if (mdl_hdr[1][7]) st = ST_EXC;
      fn = mdl_hdr[1];
      plen = len - 4;
    end else begin
      pdu = {mdl_hdr[4], mdl_hdr[5]};
      if (mdl_rsp_bad || len < 9 || mdl_hdr[2] != 0 || mdl_hdr[3] != 0 ||
          mdl_hdr[6] != mdl_unit || pdu < 2 || pdu + 6 != len) st = ST_FRAME;
      else if (mdl_hdr[7][7]) st = ST_EXC;
      fn = mdl_hdr[7];
      plen = len - 8;
    end
    r = mk(KIND_RESP_VERD, 8'd0, st);
    if (st == ST_OK) begin
      r.resp_unit = mdl_unit;
      r.resp_function = fn;
      r.resp_payload_len = plen[8:0];
    end
    return r;
  endfunction

  // Results caused by one accepted item; also advances the model state.
  function automatic void predict_item(logic [1:0] o, logic [7:0] d, logic [7:0] n,
                                       logic lst);
    result_t res[$];
    int unsigned i;
    logic [8:0] plen;
    if (o == OP_START) begin
      if (d == 0 || n > MaxReqLen) begin
        res.push_back(mk(KIND_REQ_VERD, 8'd0, ST_INVAL));
      end else if (!mdl_tcp) begin
        mdl_req_crc = crc16_byte(crc16_byte(16'hFFFF, mdl_unit), d);
        res.push_back(mk(KIND_REQ_BYTE, mdl_unit, ST_OK));
        res.push_back(mk(KIND_REQ_BYTE, d, ST_OK));
        mdl_req_left = n;
        mdl_req_open = 1'b1;
        if (n == 0) begin
          res.push_back(mk(KIND_REQ_BYTE, mdl_req_crc[7:0], ST_OK));
          res.push_back(mk(KIND_REQ_BYTE, mdl_req_crc[15:8], ST_OK));
          mdl_req_open = 1'b0;
        end
      end else begin
        plen = n + 9'd2;
        mdl_tid = mdl_tid + 16'd1;
        res.push_back(mk(KIND_REQ_BYTE, mdl_tid[15:8], ST_OK));
        res.push_back(mk(KIND_REQ_BYTE, mdl_tid[7:0], ST_OK));
        res.push_back(mk(KIND_REQ_BYTE, 8'd0, ST_OK));
        res.push_back(mk(KIND_REQ_BYTE, 8'd0, ST_OK));
        res.push_back(mk(KIND_REQ_BYTE, {7'd0, plen[8]}, ST_OK));
        res.push_back(mk(KIND_REQ_BYTE, plen[7:0], ST_OK));
        res.push_back(mk(KIND_REQ_BYTE, mdl_unit, ST_OK));
        res.push_back(mk(KIND_REQ_BYTE, d, ST_OK));
        mdl_req_left = n;
        mdl_req_open = (n != 0);
      end
    end else if (o == OP_REQ) begin
      if (!mdl_req_open || mdl_req_left == 0) begin
        mdl_req_open = 1'b0;
        res.push_back(mk(KIND_REQ_VERD, 8'd0, ST_INVAL));
      end else begin
        res.push_back(mk(KIND_REQ_BYTE, d, ST_OK));
        mdl_req_left = mdl_req_left - 8'd1;
        if (!mdl_tcp) begin
          mdl_req_crc = crc16_byte(mdl_req_crc, d);
          if (mdl_req_left == 0) begin
            res.push_back(mk(KIND_REQ_BYTE, mdl_req_crc[7:0], ST_OK));
            res.push_back(mk(KIND_REQ_BYTE, mdl_req_crc[15:8], ST_OK));
            mdl_req_open = 1'b0;
          end
        end else if (mdl_req_left == 0) begin
          mdl_req_open = 1'b0;
        end
      end
    end else if (o == OP_RESP) begin
      i = mdl_rsp_count;
      if (i >= FrameBytes || i >= CountMax) mdl_rsp_bad = 1'b1;
      if (i < 8) mdl_hdr[i] = d;
      if (!mdl_tcp) begin
        if (i < 2) begin
          mdl_rsp_crc = crc16_byte(mdl_rsp_crc, d);
        end else begin
          if (i >= 4) begin
            mdl_rsp_crc = crc16_byte(mdl_rsp_crc, mdl_hold[0]);
            res.push_back(mk(KIND_RESP_BYTE, mdl_hold[0], ST_OK));
          end
          mdl_hold[0] = mdl_hold[1];
          mdl_hold[1] = d;
        end
      end else if (i >= 8) begin
        res.push_back(mk(KIND_RESP_BYTE, d, ST_OK));
      end
      if (i < CountMax) mdl_rsp_count = 9'(i + 1);
      if (lst) begin
        res.push_back(response_verdict(i + 1));
        clear_response();
      end
    end
    if (res.size() > 0) res[res.size() - 1].end_of_run = 1'b1;
    board.note_item(res);
  endfunction

  // Random gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Output side: random stalls, and every accepted result is checked.
  initial begin
    int g;
    receiver_busy = 1'b0;
    @(posedge clk);
    forever begin
      g = (receiver_busy) ? gap_len() : 0;
      if (g != 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result({kind, byte_out, status, resp_unit, resp_function,
                          resp_payload_len, end_of_run});
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Send one item and wait until it is accepted.
  task automatic send_item(logic [1:0] o, logic [7:0] d, logic [7:0] n, logic lst);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    data <= d;
    length <= n;
    last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(o, d, n, lst);
  endtask

  task automatic end_items();
    in_valid <= 1'b0;
  endtask

  // Wait for every expected result, then idle before returning.
  task automatic drain();
    end_items();
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Register write: setup cycle then access cycle.
  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LINK_MODE) mdl_tcp = value[0];
    else mdl_unit = value[7:0];
  endtask

  task automatic set_mode(logic tcp, logic [7:0] unit_id);
    drain();
    write_reg(REG_LINK_MODE, {31'd0, tcp});
    write_reg(REG_UNIT, {24'd0, unit_id});
  endtask

  // A full request: start then its payload bytes.
  task automatic send_request(logic [7:0] fn, int n);
    send_item(OP_START, fn, n[7:0], 1'b0);
    for (int k = 0; k < n; k++)
      send_item(OP_REQ, 8'($urandom_range(255)), 8'($urandom()), 1'b0);
  endtask

  // A response frame, well formed unless spoil is set, with pl payload bytes.
  task automatic send_response(int pl, logic exc, logic spoil);
    logic [7:0] fr[$];
    logic [15:0] crc;
    logic [7:0] fn;
    int pos;
    fn = {exc, 7'($urandom_range(127, 1))};
    if (!mdl_tcp) begin
      fr.push_back(mdl_unit);
      fr.push_back(fn);
      for (int k = 0; k < pl; k++) fr.push_back(8'($urandom_range(255)));
      crc = 16'hFFFF;
      foreach (fr[k]) crc = crc16_byte(crc, fr[k]);
      fr.push_back(crc[7:0]);
      fr.push_back(crc[15:8]);
    end else begin
      fr.push_back(8'($urandom_range(255)));
      fr.push_back(8'($urandom_range(255)));
      fr.push_back(8'd0);
      fr.push_back(8'd0);
      fr.push_back(8'((pl + 2) >> 8));
      fr.push_back(8'(pl + 2));
      fr.push_back(mdl_unit);
      fr.push_back(fn);
      for (int k = 0; k < pl; k++) fr.push_back(8'($urandom_range(255)));
    end
    if (spoil) begin
      pos = $urandom_range(fr.size() - 1);
      fr[pos] = fr[pos] ^ 8'(1 << $urandom_range(7));
    end
    foreach (fr[k]) send_item(OP_RESP, fr[k], 8'($urandom()), k == fr.size() - 1);
  endtask

  // One random step of the mixed stimulus.
  task automatic random_step(inout int count);
    int unsigned r;
    int n;
    r = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(4);
    if (r < 40) begin
      send_request(8'($urandom_range(255, 1)), n);
      count += n + 1;
    end else if (r < 80) begin
      send_response(n, $urandom_range(3) == 0, $urandom_range(4) == 0);
      count += n + (mdl_tcp ? 8 : 4);
    end else begin
      send_item(2'($urandom_range(3)), 8'($urandom()), 8'($urandom()),
                $urandom_range(5) == 0);
      count++;
    end
  endtask

  initial begin
    int count;
    mdl_tcp = 1'b0;
    mdl_unit = 8'd1;
    mdl_tid = '0;
    mdl_req_crc = 16'hFFFF;
    mdl_req_left = '0;
    mdl_req_open = 1'b0;
    clear_response();
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed RTU items under reset settings.
    send_item(OP_START, 8'h03, 8'd2, 1'b0);
    send_item(OP_REQ, 8'h00, 8'hFF, 1'b0);
    send_item(OP_REQ, 8'hFF, 8'h00, 1'b1);
    send_item(OP_REQ, 8'h55, 8'd0, 1'b0);
    send_item(OP_START, 8'h00, 8'd1, 1'b0);
    send_item(OP_START, 8'hFF, 8'd252, 1'b0);
    send_item(OP_START, 8'hFF, 8'd0, 1'b0);
    send_item(OP_START, 8'h10, 8'd5, 1'b0);
    send_item(OP_START, 8'h81, 8'd251, 1'b0);
    send_item(2'd3, 8'hAA, 8'h55, 1'b1);
    send_item(OP_RESP, 8'h01, 8'd0, 1'b1);
    send_response(0, 1'b0, 1'b0);
    send_response(3, 1'b1, 1'b0);
    send_response(2, 1'b0, 1'b1);
    // A mode change inside a response frame.
    send_item(OP_RESP, 8'd1, 8'd0, 1'b0);
    drain();
    write_reg(REG_LINK_MODE, 32'd1);

    // Directed TCP items.
    send_item(OP_RESP, 8'h00, 8'd0, 1'b1);
    send_item(OP_START, 8'h04, 8'd0, 1'b0);
    send_item(OP_START, 8'h05, 8'd251, 1'b0);
    send_item(OP_REQ, 8'h12, 8'd0, 1'b0);
    send_response(0, 1'b0, 1'b0);
    send_response(4, 1'b1, 1'b0);
    set_mode(1'b1, 8'd247);

    // Random phases across modes and unit ids, extremes included.
    count = 0;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 3) begin
        // Overlong response frame in RTU mode.
        set_mode(1'b0, 8'd1);
        for (int k = 0; k < 262; k++) send_item(OP_RESP, 8'($urandom()), 8'd0, k == 261);
      end
      while (count < 10 * (phase + 1)) random_step(count);
      set_mode(phase[0], (phase == 6) ? 8'd247 : 8'($urandom_range(247, 1)));
    end
    // Hold the sender until every expected result has come.
    drain();
    receiver_busy = 1'b1;
    for (int k = 0; k < 4; k++) random_step(count);
    drain();

    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // The main sequence makes the receiver busy only at the end; turn it on early.
  initial begin
    @(negedge rst);
    repeat (200) @(posedge clk);
    receiver_busy = 1'b1;
  end

endmodule

// File: modbus_client_frame_engine.f
hdl/mcfe_pkg.sv
hdl/mcfe_front.sv
hdl/mcfe_queue.sv
hdl/mcfe_back.sv
hdl/modbus_client_frame_engine.sv
hdl/mcfe_checker.sv
sim/testbench.sv
